// ===== rtl/lca_pkg.sv =====
// Package for the binary-lifting lowest common ancestor block.
// Holds field widths, controller states, datapath operations and the
// command and status structs. No dependencies.
package lca_pkg;

  localparam int NODE_W     = 10;
  localparam int DEPTH_W    = 10;
  localparam int NODE_COUNT = 1 << NODE_W;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_DEPTH,
    ST_ADD_ROOT,
    ST_ADD_LEVEL,
    ST_Q_DEPTH,
    ST_Q_ORDER,
    ST_Q_LIFT,
    ST_Q_CMP,
    ST_Q_JUMP,
    ST_Q_FIN,
    ST_DONE
  } lca_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_ADD_DEPTH,
    OP_ADD_ROOT,
    OP_ADD_LEVEL,
    OP_Q_DEPTH,
    OP_Q_ORDER,
    OP_Q_LIFT,
    OP_Q_CMP,
    OP_Q_JUMP,
    OP_Q_FIN
  } lca_op_t;

  typedef struct packed {
    lca_op_t op;
    logic    load_out;
  } lca_cmd_t;

  typedef struct packed {
    logic query;
    logic add_ok;
    logic same;
  } lca_stat_t;

endpackage

// ===== rtl/lca_if.sv =====
// Handshake interfaces for the request and result channels.
// Depends on lca_pkg for the field widths.
interface lca_item_if import lca_pkg::*;;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  modport source (output valid, output mode, output node_a, output node_b, input ready);
  modport sink   (input valid, input mode, input node_a, input node_b, output ready);
endinterface

interface lca_res_if import lca_pkg::*;;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] ancestor;

  modport source (output valid, output ancestor, input ready);
  modport sink   (input valid, input ancestor, output ready);
endinterface

// ===== rtl/lca_dp.sv =====
// Datapath: ancestor table and depth memories, node registers, result register.
// Depends on lca_pkg; driven by lca_ctrl through a command struct.
module lca_dp import lca_pkg::*; #(
  parameter int MAX_NODES  = 1024,
  parameter int LOG_LEVELS = 10,
  localparam int LvlW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1
) (
  input  logic              clk,
  input  lca_cmd_t          cmd,
  input  logic [LvlW-1:0]   lvl,
  input  logic [LvlW-1:0]   rlvl,
  input  logic              item_mode,
  input  logic [NODE_W-1:0] item_a,
  input  logic [NODE_W-1:0] item_b,
  output lca_stat_t         stat,
  output logic [NODE_W-1:0] ancestor
);

  localparam int Depth    = (MAX_NODES < NODE_COUNT) ? MAX_NODES : NODE_COUNT;
  localparam int AW       = $clog2(Depth);
  localparam int TblDepth = Depth << LvlW;

  logic [AW-1:0]      tbl [TblDepth];
  logic [DEPTH_W-1:0] dep [Depth];

  logic [AW-1:0]      u, v, res;
  logic [AW-1:0]      u_next, v_next, res_next;
  logic [DEPTH_W-1:0] dv, dv_next;

  logic [AW-1:0]      clip_a, clip_b;
  logic               a_ok, b_ok;

  // Table ports.
  logic [AW-1:0]      t_ra0, t_ra1, t_wa, t_wd;
  logic [LvlW-1:0]    t_rlvl, t_wlvl;
  logic               t_we;
  logic [AW-1:0]      t_q0, t_q1, t_wd_q;
  logic               t_z0, t_z1, t_b0, t_b1;
  logic [AW-1:0]      t0, t1;

  // Depth ports.
  logic [AW-1:0]      d_ra0, d_ra1, d_wa;
  logic [DEPTH_W-1:0] d_wd;
  logic               d_we;
  logic [DEPTH_W-1:0] d_q0, d_q1;
  logic               d_z0, d_z1;
  logic [DEPTH_W-1:0] d0, d1;

  logic [DEPTH_W-1:0] diff;
  logic               swap, take, differ;

  assign a_ok   = 32'(item_a) < MAX_NODES;
  assign b_ok   = 32'(item_b) < MAX_NODES;
  assign clip_a = a_ok ? item_a[AW-1:0] : '0;
  assign clip_b = b_ok ? item_b[AW-1:0] : '0;

  assign stat.query  = item_mode;
  assign stat.add_ok = (clip_a != '0) && b_ok;
  assign stat.same   = (u == v);

  // Node 0 is never written and always reads as zero. A table read of the entry
  // written in the same cycle returns the new data.
  assign t0 = t_b0 ? t_wd_q : (t_z0 ? '0 : t_q0);
  assign t1 = t_b1 ? t_wd_q : (t_z1 ? '0 : t_q1);
  assign d0 = d_z0 ? '0 : d_q0;
  assign d1 = d_z1 ? '0 : d_q1;

  assign diff = d0 - dv;

  always_comb begin
    u_next   = u;
    v_next   = v;
    dv_next  = dv;
    res_next = res;
    t_ra0    = u;
    t_ra1    = v;
    t_rlvl   = rlvl;
    t_we     = 1'b0;
    t_wa     = u;
    t_wlvl   = lvl;
    t_wd     = t0;
    d_ra0    = u;
    d_ra1    = v;
    d_we     = 1'b0;
    d_wa     = u;
    d_wd     = (d0 == DEPTH_MAX) ? DEPTH_MAX : d0 + DEPTH_W'(1);
    swap     = d0 < d1;
    take     = (d0 >= dv) && ((diff >> lvl) != '0);
    differ   = t0 != t1;
    case (cmd.op)
      OP_CAPTURE: begin
        u_next   = clip_a;
        v_next   = clip_b;
        res_next = '0;
      end
      OP_ADD_DEPTH: begin
        d_ra0  = v;
        t_we   = 1'b1;
        t_wlvl = '0;
        t_wd   = v;
      end
      OP_ADD_ROOT: begin
        d_we = 1'b1;
        if (v == '0) begin
          d_wd = '0;
        end
        t_ra0  = v;
        t_rlvl = '0;
      end
      OP_ADD_LEVEL: begin
        t_we   = 1'b1;
        t_ra0  = t0;
        t_rlvl = lvl;
      end
      OP_Q_DEPTH: begin
        d_ra0 = u;
        d_ra1 = v;
      end
      OP_Q_ORDER: begin
        u_next  = swap ? v : u;
        v_next  = swap ? u : v;
        dv_next = swap ? d0 : d1;
        d_ra0   = u_next;
        t_ra0   = u_next;
      end
      OP_Q_LIFT: begin
        u_next = take ? t0 : u;
        d_ra0  = u_next;
        t_ra0  = u_next;
      end
      OP_Q_CMP: begin
        res_next = u;
      end
      OP_Q_JUMP: begin
        u_next = differ ? t0 : u;
        v_next = differ ? t1 : v;
        t_ra0  = u_next;
        t_ra1  = v_next;
      end
      OP_Q_FIN: begin
        res_next = t0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    u   <= u_next;
    v   <= v_next;
    dv  <= dv_next;
    res <= res_next;
    if (cmd.load_out) begin
      ancestor <= NODE_W'(res);
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tbl[{t_wa, t_wlvl}] <= t_wd;
    end
    t_q0   <= tbl[{t_ra0, t_rlvl}];
    t_q1   <= tbl[{t_ra1, t_rlvl}];
    t_z0   <= (t_ra0 == '0);
    t_z1   <= (t_ra1 == '0);
    t_b0   <= t_we && ({t_ra0, t_rlvl} == {t_wa, t_wlvl});
    t_b1   <= t_we && ({t_ra1, t_rlvl} == {t_wa, t_wlvl});
    t_wd_q <= t_wd;
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dep[d_wa] <= d_wd;
    end
    d_q0 <= dep[d_ra0];
    d_q1 <= dep[d_ra1];
    d_z0 <= (d_ra0 == '0);
    d_z1 <= (d_ra1 == '0);
  end

endmodule

// ===== rtl/lca_ctrl.sv =====
// Controller: sequences adds and queries over the datapath, owns the level
// counter and the result valid flag. Depends on lca_pkg.
module lca_ctrl import lca_pkg::*; #(
  parameter int LOG_LEVELS = 10,
  localparam int LvlW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  output logic            res_valid,
  input  logic            res_ready,
  input  lca_stat_t       stat,
  output lca_cmd_t        cmd,
  output logic [LvlW-1:0] lvl,
  output logic [LvlW-1:0] rlvl
);

  localparam logic [LvlW-1:0] LastLvl = LvlW'(LOG_LEVELS - 1);

  lca_state_t      state, state_next;
  logic [LvlW-1:0] lvl_next;
  logic            res_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lvl       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      lvl       <= lvl_next;
      res_valid <= res_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    lvl_next       = lvl;
    res_valid_next = res_valid && !res_ready;
    cmd.op         = OP_NONE;
    cmd.load_out   = 1'b0;
    item_ready     = 1'b0;
    rlvl           = LastLvl;
    case (state)
      ST_IDLE: begin
        item_ready = !rst;
        if (item_valid) begin
          cmd.op = OP_CAPTURE;
          if (stat.query) begin
            state_next = ST_Q_DEPTH;
          end else if (stat.add_ok) begin
            state_next = ST_ADD_DEPTH;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_ADD_DEPTH: begin
        cmd.op     = OP_ADD_DEPTH;
        state_next = ST_ADD_ROOT;
      end
      ST_ADD_ROOT: begin
        cmd.op     = OP_ADD_ROOT;
        lvl_next   = (LOG_LEVELS > 1) ? LvlW'(1) : '0;
        state_next = (LOG_LEVELS > 1) ? ST_ADD_LEVEL : ST_DONE;
      end
      ST_ADD_LEVEL: begin
        cmd.op = OP_ADD_LEVEL;
        if (lvl == LastLvl) begin
          state_next = ST_DONE;
        end else begin
          lvl_next = lvl + LvlW'(1);
        end
      end
      ST_Q_DEPTH: begin
        cmd.op     = OP_Q_DEPTH;
        state_next = ST_Q_ORDER;
      end
      ST_Q_ORDER: begin
        cmd.op     = OP_Q_ORDER;
        lvl_next   = LastLvl;
        state_next = ST_Q_LIFT;
      end
      ST_Q_LIFT: begin
        cmd.op = OP_Q_LIFT;
        rlvl   = (lvl == '0) ? '0 : lvl - LvlW'(1);
        if (lvl == '0) begin
          state_next = ST_Q_CMP;
        end else begin
          lvl_next = lvl - LvlW'(1);
        end
      end
      ST_Q_CMP: begin
        cmd.op     = OP_Q_CMP;
        lvl_next   = LastLvl;
        state_next = stat.same ? ST_DONE : ST_Q_JUMP;
      end
      ST_Q_JUMP: begin
        cmd.op = OP_Q_JUMP;
        // The last jump fetches level 0 of the new node for the final parent.
        rlvl   = (lvl == '0) ? '0 : lvl - LvlW'(1);
        if (lvl == '0) begin
          state_next = ST_Q_FIN;
        end else begin
          lvl_next = lvl - LvlW'(1);
        end
      end
      ST_Q_FIN: begin
        cmd.op     = OP_Q_FIN;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!res_valid || res_ready) begin
          cmd.load_out   = 1'b1;
          res_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> (state != ST_IDLE))
    else $error("accepted transaction did not start work");

  a_lvl_bounded: assert property (@(posedge clk) disable iff (rst)
    lvl <= LastLvl)
    else $error("level counter beyond the last level");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_valid && !res_ready) |=> (state == ST_DONE))
    else $error("result dropped while output register was busy");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside the completion state");

endmodule

// ===== rtl/lca_binary_lifting_top.sv =====
// Channel   Dir  Fields                          Transaction
// item      in   mode[0], node_a[9:0], node_b    valid && ready
// result    out  ancestor[9:0]                   valid && ready
//
// One item at a time. An add makes one table write per level; an ignored
// add goes straight from acceptance to completion. A query makes one table
// read per level in each of two passes, lifting and then jumping; the jump
// pass is skipped when the lifted node meets the other.
// Synchronous reset clears control only; no memory clearing pass is needed.
// A waiting result does not block acceptance of the next item; the block
// stalls at completion only while the result register is still occupied.
//
// Top level of the binary-lifting lowest common ancestor block.
// Depends on lca_pkg, lca_if, lca_ctrl and lca_dp.
module lca_binary_lifting_top import lca_pkg::*; #(
  parameter int MAX_NODES  = 1024,
  parameter int LOG_LEVELS = 10
) (
  input  logic       clk,
  input  logic       rst,
  lca_item_if.sink   item,
  lca_res_if.source  result
);

  localparam int LvlW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;

  lca_cmd_t        cmd;
  lca_stat_t       stat;
  logic [LvlW-1:0] lvl;
  logic [LvlW-1:0] rlvl;

  lca_ctrl #(
    .LOG_LEVELS (LOG_LEVELS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .stat       (stat),
    .cmd        (cmd),
    .lvl        (lvl),
    .rlvl       (rlvl)
  );

  lca_dp #(
    .MAX_NODES  (MAX_NODES),
    .LOG_LEVELS (LOG_LEVELS)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .lvl       (lvl),
    .rlvl      (rlvl),
    .item_mode (item.mode),
    .item_a    (item.node_a),
    .item_b    (item.node_b),
    .stat      (stat),
    .ancestor  (result.ancestor)
  );

endmodule
